// ===== sv/vbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbc_pkg: shared types and constants of the Vigenere byte cipher
// Character codes, key layout, register indexes and the config struct.
// ----------------------------------------------------------------------------
package vbc_pkg;

  // Key geometry
  localparam int MAX_KEY_LEN = 12;
  localparam int LETTER_W    = 5;
  localparam int KEY_W       = MAX_KEY_LEN * LETTER_W;
  localparam int POS_W       = 4;

  // Character codes
  localparam logic [7:0] CHAR_A     = 8'd65;
  localparam logic [7:0] CHAR_Z     = 8'd90;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [5:0] ALPHA_SIZE = 6'd26;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DECRYPT_MODE = 2'd0,
    REG_KEY_LETTERS  = 2'd1,
    REG_KEY_LENGTH   = 2'd2
  } cfg_reg_e;

  typedef logic [MAX_KEY_LEN-1:0][LETTER_W-1:0] key_array_t;

  // Live configuration shared by the datapath modules
  typedef struct packed {
    logic             decrypt;
    key_array_t       letters;
    logic [POS_W-1:0] length;
  } cipher_cfg_t;

endpackage : vbc_pkg
`default_nettype wire

// ===== sv/vbc_keypos.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbc_keypos: key position tracker
// Holds the key position, picks the key letter for the current byte and
// advances the position on every accepted non-space byte.
// ----------------------------------------------------------------------------
module vbc_keypos import vbc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cipher_cfg_t         cfg_i,
  input  wire logic                fire_i,
  input  wire logic [7:0]          in_byte_i,
  input  wire logic                line_start_i,
  output logic      [LETTER_W-1:0] key_o
);

  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    eff_len;
  logic [POS_W-1:0]    pos_cur;
  logic [POS_W-1:0]    pos_use;
  logic [POS_W-1:0]    pos_inc;
  logic [POS_W-1:0]    pos_nxt;
  logic [LETTER_W-1:0] raw_key;

  // Clamp the key length to 1..MAX_KEY_LEN
  always_comb begin
    if (cfg_i.length == '0) begin
      eff_len = POS_W'(1);
    end else if (cfg_i.length > POS_W'(MAX_KEY_LEN)) begin
      eff_len = POS_W'(MAX_KEY_LEN);
    end else begin
      eff_len = cfg_i.length;
    end
  end

  // Select the letter; a position past the length falls back to zero
  always_comb begin
    pos_cur = line_start_i ? '0 : pos_q;
    pos_use = (pos_cur >= eff_len) ? '0 : pos_cur;
    raw_key = cfg_i.letters[pos_use];
    key_o   = (raw_key >= LETTER_W'(ALPHA_SIZE)) ? raw_key - LETTER_W'(ALPHA_SIZE) : raw_key;
    pos_inc = pos_use + POS_W'(1);
    pos_nxt = (pos_inc >= eff_len) ? '0 : pos_inc;
  end

  // Advance on non-space beats; a space only takes the line-start reset
  always_comb begin
    pos_d = pos_q;
    if (fire_i) begin
      pos_d = (in_byte_i != CHAR_SPACE) ? pos_nxt : pos_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule : vbc_keypos
`default_nettype wire

// ===== sv/vbc_shift.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbc_shift: modulo-26 letter shifter
// Shifts A-Z by the key letter forward or backward; other bytes pass.
// ----------------------------------------------------------------------------
module vbc_shift import vbc_pkg::*; (
  input  wire logic                decrypt_i,
  input  wire logic [7:0]          in_byte_i,
  input  wire logic [LETTER_W-1:0] key_i,
  output logic      [7:0]          out_byte_o
);

  logic [5:0] x;
  logic [5:0] sum;
  logic [5:0] y;

  always_comb begin
    x = 6'(in_byte_i - CHAR_A);
    // Add the key, or add its complement to 26 when decrypting
    if (decrypt_i) begin
      sum = x + ALPHA_SIZE - 6'(key_i);
    end else begin
      sum = x + 6'(key_i);
    end
    y = (sum >= ALPHA_SIZE) ? sum - ALPHA_SIZE : sum;
    if (in_byte_i inside {[CHAR_A:CHAR_Z]}) begin
      out_byte_o = CHAR_A + 8'(y);
    end else begin
      out_byte_o = in_byte_i;
    end
  end

endmodule : vbc_shift
`default_nettype wire

// ===== sv/vigenere_byte_cipher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vigenere_byte_cipher_core: Vigenere cipher over a byte stream
// Shifts uppercase letters by a repeating key of up to twelve letters.
//
//   channel  signals                              width   direction
//   in       in_valid_i/in_ready_o, in_byte_i,     8+1     sink
//            line_start_i
//   out      out_valid_o/out_ready_i, out_byte_o   8       source
//   cfg      cfg_we_i, cfg_idx_i, cfg_data_i       2+60    write only
//
// One beat per cycle sustained while the output is not stalled; an accepted
// beat passes the input register, then the result register, to output valid.
// The key position is updated when a beat is accepted, so the next beat
// can follow in the next cycle.
// Reset clears the key position, the config to its defaults and all valids.
// A stall at the output backs up through the two registers.
// ----------------------------------------------------------------------------
module vigenere_byte_cipher_core import vbc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [KEY_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             line_start_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [7:0]       out_byte_o
);

  cipher_cfg_t         cfg_q;
  logic                in_fire;
  logic [LETTER_W-1:0] key_sel;
  logic                s1_valid_q;
  logic [7:0]          s1_byte_q;
  logic [LETTER_W-1:0] s1_key_q;
  logic                s1_ready;
  logic                s2_ready;
  logic [7:0]          shifted;
  logic                out_valid_q;
  logic [7:0]          out_byte_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decrypt <= 1'b0;
      cfg_q.letters <= '0;
      cfg_q.length  <= POS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DECRYPT_MODE: cfg_q.decrypt <= cfg_data_i[0];
        REG_KEY_LETTERS:  cfg_q.letters <= key_array_t'(cfg_data_i);
        REG_KEY_LENGTH:   cfg_q.length  <= cfg_data_i[POS_W-1:0];
        default:          ;
      endcase
    end
  end

  // Pipeline flow control
  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign in_fire    = in_valid_i && s1_ready;

  vbc_keypos u_keypos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fire_i       (in_fire),
    .in_byte_i    (in_byte_i),
    .line_start_i (line_start_i),
    .key_o        (key_sel)
  );

  // Input register: hold the byte and its key letter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_byte_i;
      s1_key_q  <= key_sel;
    end
  end

  vbc_shift u_shift (
    .decrypt_i  (cfg_q.decrypt),
    .in_byte_i  (s1_byte_q),
    .key_i      (s1_key_q),
    .out_byte_o (shifted)
  );

  // Result register: advance when the output slot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      out_byte_q <= shifted;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule : vigenere_byte_cipher_core
`default_nettype wire
